// ===== hdl/hed_pkg.sv =====
`timescale 1ns / 1ps

package hed_pkg;

	// Sizes of the candidate store and of the per-byte result list
	localparam int HOLD_DEPTH = 5;
	localparam int HELD_ENTRIES = HOLD_DEPTH - 1;
	localparam int HELD_IDX_W = $clog2(HELD_ENTRIES);
	localparam int MAX_RES = 6;
	localparam int NUM_ENT = 7;

	typedef logic [7:0] byte_t;
	typedef logic [2:0] cnt_t;
	typedef logic [2:0] ent_idx_t;
	typedef logic [HOLD_DEPTH-1:0][7:0] ent_body_t;

	// Characters with a role of their own
	localparam byte_t CHAR_AMP = 8'h26;

	// Entity indexes, in priority order
	localparam ent_idx_t ENT_AMP  = 3'd0;
	localparam ent_idx_t ENT_LT   = 3'd1;
	localparam ent_idx_t ENT_GT   = 3'd2;
	localparam ent_idx_t ENT_QUOT = 3'd3;
	localparam ent_idx_t ENT_APOS = 3'd4;
	localparam ent_idx_t ENT_NUM  = 3'd5;
	localparam ent_idx_t ENT_NBSP = 3'd6;

	// Body of each entity after the ampersand, first character in byte 0
	function automatic ent_body_t ent_body(input ent_idx_t e);
		ent_body_t body;
		case (e)
			ENT_AMP:  body = {8'h00, 8'h3b, 8'h70, 8'h6d, 8'h61};
			ENT_LT:   body = {8'h00, 8'h00, 8'h3b, 8'h74, 8'h6c};
			ENT_GT:   body = {8'h00, 8'h00, 8'h3b, 8'h74, 8'h67};
			ENT_QUOT: body = {8'h3b, 8'h74, 8'h6f, 8'h75, 8'h71};
			ENT_APOS: body = {8'h3b, 8'h73, 8'h6f, 8'h70, 8'h61};
			ENT_NUM:  body = {8'h00, 8'h3b, 8'h39, 8'h33, 8'h23};
			ENT_NBSP: body = {8'h3b, 8'h70, 8'h73, 8'h62, 8'h6e};
			default:  body = '0;
		endcase
		return body;
	endfunction

	// Number of body characters of each entity
	function automatic cnt_t ent_len(input ent_idx_t e);
		cnt_t len;
		case (e)
			ENT_AMP:  len = 3'd4;
			ENT_LT:   len = 3'd3;
			ENT_GT:   len = 3'd3;
			ENT_QUOT: len = 3'd5;
			ENT_APOS: len = 3'd5;
			ENT_NUM:  len = 3'd4;
			ENT_NBSP: len = 3'd5;
			default:  len = 3'd0;
		endcase
		return len;
	endfunction

	// Decoded character of each entity
	function automatic byte_t ent_char(input ent_idx_t e);
		byte_t c;
		case (e)
			ENT_AMP:  c = 8'h26;
			ENT_LT:   c = 8'h3c;
			ENT_GT:   c = 8'h3e;
			ENT_QUOT: c = 8'h22;
			ENT_APOS: c = 8'h27;
			ENT_NUM:  c = 8'h27;
			ENT_NBSP: c = 8'h20;
			default:  c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// ===== hdl/html_entity_decoder.sv =====
`timescale 1ns / 1ps

// Streaming HTML entity decoder. Bytes enter one per transfer and leave in
// order with &amp; &lt; &gt; &quot; &apos; &#39; &nbsp; replaced by their
// single characters (&nbsp; gives a space); anything that stops matching
// is released literally, ampersand first. A byte is registered on entry and
// decoded into a list of up to six result bytes, which an output shift
// register hands out one per cycle while out_stall is low. A byte that yields
// at most one result lets the next byte in as its result leaves, so plain text
// runs at one byte per clock while out_stall is low. A byte that releases
// several results stalls the input until its last result is being taken.
// in_last flushes any pending candidate, and out_last rises on the final result of that byte.
module html_entity_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       out_last
);

	// Input stage
	logic               valid_s1;
	hed_pkg::byte_t     byte_s1;
	logic               last_s1;

	// Candidate state
	logic               amp_q;
	hed_pkg::cnt_t      held_cnt_q;
	hed_pkg::byte_t     held_q [hed_pkg::HELD_ENTRIES];

	// Result list
	hed_pkg::byte_t     res_q [hed_pkg::MAX_RES];
	hed_pkg::cnt_t      cnt_q;
	logic               last_q;

	// Decode
	hed_pkg::cnt_t      cand_len;
	logic               hit;
	hed_pkg::byte_t     hit_char;
	logic               prefix;
	logic               hold;
	logic               use_lit;
	logic               use_tail;
	hed_pkg::byte_t     tail;
	logic               amp_d;
	hed_pkg::byte_t     res_d [hed_pkg::MAX_RES];
	hed_pkg::cnt_t      cnt_d;

	logic               in_xfer;
	logic               out_xfer;
	logic               load_ok;
	logic               s1_adv;

	// Handshake
	assign load_ok  = (cnt_q == '0) || ((cnt_q == 3'd1) && !out_stall);
	assign s1_adv   = valid_s1 && load_ok;
	assign in_stall = valid_s1 && !load_ok;
	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid && !out_stall;

	assign out_valid = (cnt_q != '0);
	assign out_byte  = res_q[0];
	assign out_last  = last_q && (cnt_q == 3'd1);

	// Register the input byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	// Match the held bytes plus the new byte against every entity
	assign cand_len = held_cnt_q + 3'd1;

	always_comb begin
		hed_pkg::ent_body_t body;
		logic               ok;
		hit      = 1'b0;
		hit_char = '0;
		prefix   = 1'b0;
		body     = '0;
		ok       = 1'b0;
		// Walk downwards so that the first entity in the list wins
		for (int e = hed_pkg::NUM_ENT - 1; e >= 0; e--) begin
			body = hed_pkg::ent_body(3'(e));
			ok   = (body[held_cnt_q] == byte_s1);
			for (int i = 0; i < hed_pkg::HELD_ENTRIES; i++) begin
				if (3'(i) < held_cnt_q && held_q[i] != body[i]) begin
					ok = 1'b0;
				end
			end
			if (ok && cand_len == hed_pkg::ent_len(3'(e))) begin
				hit      = 1'b1;
				hit_char = hed_pkg::ent_char(3'(e));
			end
			if (ok && cand_len < hed_pkg::ent_len(3'(e))) begin
				prefix = 1'b1;
			end
		end
	end

	// Choose the literal flush, the tail byte and the next candidate state
	assign hold = amp_q && !hit && prefix && (cand_len < 3'(hed_pkg::HOLD_DEPTH));

	always_comb begin
		use_lit  = 1'b0;
		use_tail = (byte_s1 != hed_pkg::CHAR_AMP) || last_s1;
		tail     = byte_s1;
		amp_d    = (byte_s1 == hed_pkg::CHAR_AMP) && !last_s1;
		if (amp_q) begin
			if (hit) begin
				use_tail = 1'b1;
				tail     = hit_char;
				amp_d    = 1'b0;
			end else if (hold) begin
				use_lit  = last_s1;
				use_tail = last_s1;
				amp_d    = !last_s1;
			end else begin
				use_lit  = 1'b1;
			end
		end
	end

	// Assemble the result list: optional ampersand and held bytes, then tail
	always_comb begin
		for (int i = 0; i < hed_pkg::MAX_RES; i++) begin
			res_d[i] = '0;
		end
		cnt_d = '0;
		if (use_lit) begin
			res_d[0] = hed_pkg::CHAR_AMP;
			for (int i = 1; i <= hed_pkg::HELD_ENTRIES; i++) begin
				if (3'(i) <= held_cnt_q) begin
					res_d[i] = held_q[i-1];
				end
			end
			if (use_tail) begin
				res_d[cand_len] = tail;
			end
			cnt_d = cand_len + {2'b00, use_tail};
		end else if (use_tail) begin
			res_d[0] = tail;
			cnt_d    = 3'd1;
		end
	end

	// Advance the candidate state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_q      <= 1'b0;
			held_cnt_q <= '0;
		end else if (s1_adv) begin
			amp_q      <= amp_d;
			held_cnt_q <= (hold && !last_s1) ? cand_len : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && hold) begin
			held_q[held_cnt_q[hed_pkg::HELD_IDX_W-1:0]] <= byte_s1;
		end
	end

	// Load a fresh list, or shift out one result per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (s1_adv) begin
			cnt_q <= cnt_d;
		end else if (out_xfer) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			res_q  <= res_d;
			last_q <= last_s1;
		end else if (out_xfer) begin
			for (int i = 0; i < hed_pkg::MAX_RES - 1; i++) begin
				res_q[i] <= res_q[i+1];
			end
		end
	end

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'(hed_pkg::MAX_RES))
		else $error("result count beyond list depth");

	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		held_cnt_q <= 3'(hed_pkg::HELD_ENTRIES))
		else $error("held count beyond store depth");

	a_held_needs_amp: assert property (@(posedge clk) disable iff (!arst_n)
		!amp_q |-> held_cnt_q == '0)
		else $error("held bytes without a pending ampersand");

	a_last_flushes: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && last_s1) |=> (!amp_q && held_cnt_q == '0))
		else $error("candidate survives end of string");

	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && last_s1) |=> (cnt_q != '0))
		else $error("end of string gave no result");
`endif

endmodule

// ===== tb/sv/tb_html_entity_decoder.sv =====
`timescale 1ns / 1ps

module tb_html_entity_decoder;

	localparam int RANDOM_ITEMS = 450;
	localparam int WIND_DOWN = 40;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int PRINT_LIMIT = 50;
	localparam int DRAIN_CYCLES = 8;

	// One text byte waiting to be sent; pause holds it until all output is back
	typedef struct packed {
		hed_pkg::byte_t data;
		logic           last;
		logic           pause;
	} text_item_t;

	// One decoded byte as it should leave the block
	typedef struct packed {
		hed_pkg::byte_t data;
		logic           last;
	} decoded_t;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] in_byte = 8'h00;
	logic       in_last = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic       out_last;

	// Entity bodies after the ampersand, in priority order, and their characters
	string ent_text [hed_pkg::NUM_ENT] =
		'{"amp;", "lt;", "gt;", "quot;", "apos;", "#39;", "nbsp;"};
	hed_pkg::byte_t ent_glyph [hed_pkg::NUM_ENT] =
		'{8'h26, 8'h3c, 8'h3e, 8'h22, 8'h27, 8'h27, 8'h20};

	text_item_t     text_q [$];
	decoded_t       decoded_q [$];
	hed_pkg::byte_t step_bytes [$];

	// Decoder state as the predictor sees it
	logic           amp_held = 1'b0;
	hed_pkg::byte_t held_buf [hed_pkg::HELD_ENTRIES];
	int             held_n = 0;

	// Transfer taken by the driver, held in these registers for the monitor to predict
	logic           taken_v = 1'b0;
	hed_pkg::byte_t taken_byte = 8'h00;
	logic           taken_last = 1'b0;

	int         mismatch_count = 0;
	int         send_gap = 0;
	int         recv_gap = 0;
	int         send_pct = 20;
	int         recv_pct = 20;
	int         quiet_cycles = 0;
	bit         rand_last_on = 1'b0;

	html_entity_decoder i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.out_last  (out_last)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input hed_pkg::byte_t got,
		input hed_pkg::byte_t want);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT)
			$display("%0t: mismatch on %s: got %02h, want %02h", $time, what, got, want);
	endtask

	// Release the ampersand and every held byte literally
	function automatic void release_held();
		step_bytes.push_back(hed_pkg::CHAR_AMP);
		for (int i = 0; i < held_n; i++)
			step_bytes.push_back(held_buf[i]);
		amp_held = 1'b0;
		held_n = 0;
	endfunction

	// Treat a byte as fresh text: an ampersand opens a candidate
	function automatic void take_byte(input hed_pkg::byte_t b);
		if (b == hed_pkg::CHAR_AMP) begin
			amp_held = 1'b1;
			held_n = 0;
		end else begin
			step_bytes.push_back(b);
		end
	endfunction

	// Work out the decoded bytes caused by one text byte
	function automatic void decode_step(input hed_pkg::byte_t b, input logic last);
		hed_pkg::byte_t cand [hed_pkg::HOLD_DEPTH];
		int             len;
		int             hit;
		bit             prefix;
		bit             same;
		decoded_t       d;

		if (amp_held) begin
			for (int i = 0; i < held_n; i++)
				cand[i] = held_buf[i];
			cand[held_n] = b;
			len = held_n + 1;
			hit = -1;
			prefix = 1'b0;
			for (int e = 0; e < hed_pkg::NUM_ENT; e++) begin
				if (len <= ent_text[e].len()) begin
					same = 1'b1;
					for (int i = 0; i < len; i++)
						if (hed_pkg::byte_t'(ent_text[e][i]) != cand[i])
							same = 1'b0;
					if (same && len == ent_text[e].len()) begin
						if (hit < 0)
							hit = e;
					end else if (same) begin
						prefix = 1'b1;
					end
				end
			end
			if (hit >= 0) begin
				step_bytes.push_back(ent_glyph[hit]);
				amp_held = 1'b0;
				held_n = 0;
			end else if (prefix && len < hed_pkg::HOLD_DEPTH) begin
				held_buf[held_n] = b;
				held_n = len;
			end else begin
				release_held();
				take_byte(b);
			end
		end else begin
			take_byte(b);
		end

		// Flush the candidate at the end of the string
		if (last && amp_held)
			release_held();

		for (int i = 0; i < step_bytes.size(); i++) begin
			d.data = step_bytes[i];
			d.last = last && (i == step_bytes.size() - 1);
			decoded_q.push_back(d);
		end
		step_bytes.delete();
	endfunction

	function automatic void add_byte(input hed_pkg::byte_t b, input logic last);
		text_item_t t;
		t.data = b;
		t.last = last | (rand_last_on && $urandom_range(0, 24) == 0);
		t.pause = 1'b0;
		text_q.push_back(t);
	endfunction

	function automatic void add_text(input string s, input logic last_at_end);
		for (int i = 0; i < s.len(); i++)
			add_byte(hed_pkg::byte_t'(s[i]), last_at_end && (i == s.len() - 1));
	endfunction

	function automatic void mark_pause(input int idx);
		text_item_t t;
		t = text_q[idx];
		t.pause = 1'b1;
		text_q[idx] = t;
	endfunction

	// Drive text bytes; hold the payload while stalled
	always @(posedge clk) begin : drive_text
		logic       took;
		text_item_t nxt;

		if (arst_n) begin
			took = in_valid && !in_stall;
			taken_v <= took;
			taken_byte <= in_byte;
			taken_last <= in_last;
			if ($urandom_range(0, 63) == 0)
				send_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);

			if (in_valid && !took) begin
				// hold
			end else if (send_gap != 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (text_q.size() != 0 &&
				!(text_q[0].pause && (took || taken_v || decoded_q.size() != 0))) begin
				nxt = text_q.pop_front();
				in_valid <= 1'b1;
				in_byte <= nxt.data;
				in_last <= nxt.last;
				if (text_q.size() >= WIND_DOWN && $urandom_range(0, 99) < send_pct)
					send_gap = $urandom_range(1, 6);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Predict taken bytes, check decoded transfers and drive the output stall
	always @(posedge clk) begin : check_out
		decoded_t want;

		if (arst_n) begin
			if (taken_v)
				decode_step(taken_byte, taken_last);

			if (out_valid && !out_stall) begin
				if (decoded_q.size() == 0) begin
					report_mismatch("unexpected byte", out_byte, 8'h00);
				end else begin
					want = decoded_q.pop_front();
					if (out_byte !== want.data)
						report_mismatch("out_byte", out_byte, want.data);
					if (out_last !== want.last)
						report_mismatch("out_last", {7'b0, out_last}, {7'b0, want.last});
				end
			end

			if ($urandom_range(0, 63) == 0)
				recv_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
			if (recv_gap != 0) begin
				recv_gap--;
				out_stall <= 1'b1;
			end else if (text_q.size() >= WIND_DOWN && $urandom_range(0, 99) < recv_pct) begin
				recv_gap = $urandom_range(0, 5);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Give up when no transfer happens for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_html_entity_decoder: FAIL");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int         directed_n;
		int         pick;
		int         e;
		int         k;
		text_item_t t;

		// Directed: zero and top byte, full hold broken, ampersand breaking,
		// numeric and ampersand entities, end of string with bytes held
		add_byte(8'h00, 1'b0);
		add_byte(8'hff, 1'b1);
		add_text("&quotx", 1'b0);
		add_text("&lt&", 1'b0);
		add_text("&#39;", 1'b0);
		add_text("&amp;", 1'b0);
		add_text("&gt", 1'b1);
		directed_n = text_q.size();

		// Random: mostly entities and broken entities, with plain noise
		rand_last_on = 1'b1;
		while (text_q.size() < directed_n + RANDOM_ITEMS) begin
			pick = $urandom_range(0, 9);
			e = $urandom_range(0, hed_pkg::NUM_ENT - 1);
			if (pick < 3) begin
				add_byte(hed_pkg::byte_t'($urandom_range(0, 255)), 1'b0);
			end else if (pick < 6) begin
				add_byte(hed_pkg::CHAR_AMP, 1'b0);
				add_text(ent_text[e], 1'b0);
			end else if (pick < 8) begin
				add_byte(hed_pkg::CHAR_AMP, 1'b0);
				k = $urandom_range(0, ent_text[e].len() - 1);
				for (int i = 0; i < k; i++)
					add_byte(hed_pkg::byte_t'(ent_text[e][i]), 1'b0);
				case ($urandom_range(0, 3))
					0: add_byte(hed_pkg::CHAR_AMP, 1'b0);
					1: add_byte(8'h3b, 1'b0);
					2: add_byte(hed_pkg::byte_t'(
						ent_text[$urandom_range(0, hed_pkg::NUM_ENT - 1)][0]), 1'b0);
					default: add_byte(hed_pkg::byte_t'($urandom_range(0, 255)), 1'b0);
				endcase
			end else if (pick == 8) begin
				add_text(ent_text[e], 1'b0);
			end else begin
				// already decoded text must not decode again
				add_byte(hed_pkg::CHAR_AMP, 1'b0);
				add_text("amp;", 1'b0);
				add_text(ent_text[e], 1'b0);
			end
		end
		t = text_q[text_q.size() - 1];
		t.last = 1'b1;
		text_q[text_q.size() - 1] = t;
		mark_pause(directed_n);
		mark_pause(directed_n + RANDOM_ITEMS / 2);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Drain, then allow for the pipeline latency
		while (text_q.size() != 0 || in_valid || taken_v || decoded_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("tb_html_entity_decoder: PASS");
		else
			$display("tb_html_entity_decoder: FAIL");
		$finish;
	end

endmodule

// ===== html_entity_decoder.f =====
hdl/hed_pkg.sv
hdl/html_entity_decoder.sv
tb/sv/tb_html_entity_decoder.sv
